// ===== rtl/core/i2cm_pkg.sv =====
// i2cm_pkg: shared types and codes of the i2c master byte engine
// no dependencies; used by i2cm_step and i2c_master_byte_engine_top
package i2cm_pkg;

  localparam int unsigned PHASE_W = 5;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned BITC_W  = 4;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_WAIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_WAIT  = 1'b1;

  localparam logic [BYTE_W-1:0] SHORT_WAIT_RST = 8'd6;
  localparam logic [BYTE_W-1:0] LONG_WAIT_RST  = 8'd12;
  localparam logic [BYTE_W-1:0] MSB_MASK       = 8'h80;
  localparam logic [BITC_W-1:0] BITS_PER_BYTE  = 4'd8;

  // item kinds
  localparam logic [CMD_W-1:0] KIND_TICK      = 3'd0;
  localparam logic [CMD_W-1:0] KIND_START     = 3'd1;
  localparam logic [CMD_W-1:0] KIND_WRITE     = 3'd2;
  localparam logic [CMD_W-1:0] KIND_READ_ACK  = 3'd3;
  localparam logic [CMD_W-1:0] KIND_READ_NAK  = 3'd4;
  localparam logic [CMD_W-1:0] KIND_STOP      = 3'd5;

  // bus sequence phases
  localparam logic [PHASE_W-1:0] PH_IDLE   = 5'd0;
  localparam logic [PHASE_W-1:0] PH_S_PRE  = 5'd1;
  localparam logic [PHASE_W-1:0] PH_S_HIGH = 5'd2;
  localparam logic [PHASE_W-1:0] PH_S_FALL = 5'd3;
  localparam logic [PHASE_W-1:0] PH_S_CLK0 = 5'd4;
  localparam logic [PHASE_W-1:0] PH_W_DATA = 5'd5;
  localparam logic [PHASE_W-1:0] PH_W_CLK  = 5'd6;
  localparam logic [PHASE_W-1:0] PH_W_REL  = 5'd7;
  localparam logic [PHASE_W-1:0] PH_W_ACKH = 5'd8;
  localparam logic [PHASE_W-1:0] PH_W_SAMP = 5'd9;
  localparam logic [PHASE_W-1:0] PH_W_END  = 5'd10;
  localparam logic [PHASE_W-1:0] PH_R_HIGH = 5'd11;
  localparam logic [PHASE_W-1:0] PH_R_SAMP = 5'd12;
  localparam logic [PHASE_W-1:0] PH_R_LOW  = 5'd13;
  localparam logic [PHASE_W-1:0] PH_R_ACK  = 5'd14;
  localparam logic [PHASE_W-1:0] PH_R_ACKH = 5'd15;
  localparam logic [PHASE_W-1:0] PH_R_END  = 5'd16;
  localparam logic [PHASE_W-1:0] PH_P_PRE  = 5'd17;
  localparam logic [PHASE_W-1:0] PH_P_LOW  = 5'd18;
  localparam logic [PHASE_W-1:0] PH_P_REL  = 5'd19;
  localparam logic [PHASE_W-1:0] PH_P_END  = 5'd20;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [CMD_W-1:0]   cmd;
    logic [BITC_W-1:0]  bitc;
    logic [BYTE_W-1:0]  shift;
    logic [BYTE_W-1:0]  waitc;
    logic               scl;
    logic               sda;
    logic               ack;
    logic [BYTE_W-1:0]  read_hold;
  } eng_state_t;

  typedef struct packed {
    logic               scl_level;
    logic               sda_level;
    logic               busy_res;
    logic               done_res;
    logic               no_ack;
    logic [BYTE_W-1:0]  read_byte;
    logic               rejected;
  } eng_res_t;

endpackage

// ===== rtl/core/i2cm_step.sv =====
// i2cm_step: next-state and result logic of the byte engine for one item
// depends on i2cm_pkg
module i2cm_step (
  input  i2cm_pkg::eng_state_t          cur,
  input  logic [i2cm_pkg::CMD_W-1:0]    kind,
  input  logic [i2cm_pkg::BYTE_W-1:0]   data,
  input  logic                          sda_in,
  input  logic [i2cm_pkg::BYTE_W-1:0]   short_wait,
  input  logic [i2cm_pkg::BYTE_W-1:0]   long_wait,
  output i2cm_pkg::eng_state_t          nxt,
  output i2cm_pkg::eng_res_t            res
);
  import i2cm_pkg::*;

  logic                 is_cmd;
  logic                 run;
  logic                 ends;
  logic                 rej;
  logic [PHASE_W-1:0]   tgt;
  logic [BYTE_W-1:0]    sw_eff;
  logic [BYTE_W-1:0]    lw_eff;

  // a zero wait counts as one tick
  assign sw_eff = (short_wait == '0) ? 8'd1 : short_wait;
  assign lw_eff = (long_wait == '0) ? 8'd1 : long_wait;

  assign is_cmd = (kind >= KIND_START) && (kind <= KIND_STOP);

  always_comb begin
    nxt  = cur;
    run  = 1'b0;
    ends = 1'b0;
    rej  = 1'b0;
    tgt  = PH_IDLE;

    if (is_cmd) begin
      if (cur.phase != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        run      = 1'b1;
        nxt.cmd  = kind;
        nxt.bitc = '0;
        unique case (kind)
          KIND_START: begin
            nxt.shift = data;
            tgt       = PH_S_PRE;
          end
          KIND_WRITE: begin
            nxt.shift = data;
            tgt       = PH_W_DATA;
          end
          KIND_READ_ACK, KIND_READ_NAK: begin
            nxt.shift = '0;
            tgt       = PH_R_HIGH;
          end
          default: begin
            tgt = PH_P_PRE;
          end
        endcase
      end
    end else if (cur.phase != PH_IDLE) begin
      if (cur.waitc > 8'd1) begin
        nxt.waitc = cur.waitc - 8'd1;
      end else begin
        run = 1'b1;
        unique case (cur.phase)
          PH_W_CLK: tgt = (cur.bitc < BITS_PER_BYTE) ? PH_W_DATA : PH_W_REL;
          PH_R_LOW: tgt = (cur.bitc < BITS_PER_BYTE) ? PH_R_HIGH : PH_R_ACK;
          PH_R_END: tgt = PH_P_LOW;
          default:  tgt = cur.phase + 5'd1;
        endcase
      end
    end

    if (run) begin
      nxt.phase = tgt;
      unique case (tgt)
        PH_S_PRE: nxt.waitc = lw_eff;
        PH_S_HIGH: begin
          nxt.sda   = 1'b1;
          nxt.scl   = 1'b1;
          nxt.waitc = lw_eff;
        end
        PH_S_FALL: begin
          nxt.sda   = 1'b0;
          nxt.waitc = lw_eff;
        end
        PH_S_CLK0: begin
          nxt.scl   = 1'b0;
          nxt.bitc  = '0;
          nxt.waitc = lw_eff;
        end
        PH_W_DATA: begin
          nxt.scl   = 1'b0;
          nxt.sda   = |(nxt.shift & MSB_MASK);
          nxt.shift = {nxt.shift[BYTE_W-2:0], 1'b0};
          nxt.waitc = sw_eff;
        end
        PH_W_CLK: begin
          nxt.scl   = 1'b1;
          nxt.bitc  = nxt.bitc + 4'd1;
          nxt.waitc = sw_eff;
        end
        PH_W_REL: begin
          nxt.scl   = 1'b0;
          nxt.sda   = 1'b1;
          nxt.waitc = lw_eff;
        end
        PH_W_ACKH: begin
          nxt.scl   = 1'b1;
          nxt.waitc = sw_eff;
        end
        PH_W_SAMP: begin
          nxt.ack   = sda_in;
          nxt.waitc = lw_eff;
        end
        PH_W_END: begin
          nxt.scl = 1'b0;
          ends    = 1'b1;
        end
        PH_R_HIGH: begin
          nxt.sda   = 1'b1;
          nxt.scl   = 1'b1;
          nxt.waitc = sw_eff;
        end
        PH_R_SAMP: begin
          nxt.shift = {nxt.shift[BYTE_W-2:0], sda_in};
          nxt.waitc = sw_eff;
        end
        PH_R_LOW: begin
          nxt.scl   = 1'b0;
          nxt.bitc  = nxt.bitc + 4'd1;
          nxt.waitc = sw_eff;
        end
        PH_R_ACK: begin
          nxt.sda       = (nxt.cmd == KIND_READ_NAK);
          nxt.read_hold = nxt.shift;
          nxt.waitc     = sw_eff;
        end
        PH_R_ACKH: begin
          nxt.scl   = 1'b1;
          nxt.waitc = lw_eff;
        end
        PH_R_END: begin
          nxt.scl = 1'b0;
          // read with nak carries on into the stop
          if (nxt.cmd != KIND_READ_NAK) begin
            ends = 1'b1;
          end else begin
            nxt.waitc = lw_eff;
          end
        end
        PH_P_PRE: nxt.waitc = lw_eff;
        PH_P_LOW: begin
          nxt.sda   = 1'b0;
          nxt.scl   = 1'b1;
          nxt.waitc = lw_eff;
        end
        PH_P_REL: begin
          nxt.sda   = 1'b1;
          nxt.waitc = lw_eff;
        end
        default: ends = 1'b1;
      endcase
      if (ends) begin
        nxt.phase = PH_IDLE;
        nxt.waitc = '0;
      end
    end
  end

  always_comb begin
    res.scl_level = nxt.scl;
    res.sda_level = nxt.sda;
    res.busy_res  = (nxt.phase != PH_IDLE);
    res.done_res  = ends;
    res.no_ack    = nxt.ack;
    res.read_byte = nxt.read_hold;
    res.rejected  = rej;
  end

endmodule

// ===== rtl/core/i2c_master_byte_engine_top.sv =====
// i2c_master_byte_engine_top: i2c master sequencer, state and result registers
// depends on i2cm_pkg and i2cm_step
//
// usage:
//   input channel (in_valid/in_ready): one item per transaction, either a tick
//   (kind 0, or the unused kinds 6 and 7) or a command (start+address, write,
//   read ack, read nak+stop, stop). a command is taken only while idle; a
//   command that arrives while busy is dropped and flagged as rejected.
//   a tick counts down the wait while busy, then advances one timing step.
//   result channel (out_valid/out_ready): exactly one result per input item,
//   carrying pin levels, busy, done, missing acknowledge and the last read byte.
//   configuration: cfg_we writes short_wait (index 0) or long_wait (index 1);
//   write only while the engine is idle.
//   the result is registered, appearing in the cycle after the input item.
//   throughput: one item per cycle while results are taken; the whole step is
//   one pass of logic between the state register and the result register.
//   a stalled receiver holds the result register; a new item is taken in the
//   same cycle the held result leaves, so back-to-back flow is kept.
//   reset: pins released high, engine idle, waits back to 6 and 12 ticks,
//   no result pending.
module i2c_master_byte_engine_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [i2cm_pkg::CMD_W-1:0]        in_kind,
  input  logic [i2cm_pkg::BYTE_W-1:0]       in_data,
  input  logic                              in_sda_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_scl_level,
  output logic                              out_sda_level,
  output logic                              out_busy_res,
  output logic                              out_done_res,
  output logic                              out_no_ack,
  output logic [i2cm_pkg::BYTE_W-1:0]       out_read_byte,
  output logic                              out_rejected,
  input  logic                              cfg_we,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [i2cm_pkg::BYTE_W-1:0]       cfg_wdata
);
  import i2cm_pkg::*;

  eng_state_t          state_r;
  eng_state_t          state_nxt;
  eng_res_t            res_r;
  eng_res_t            res_nxt;
  logic                out_valid_r;
  logic [BYTE_W-1:0]   short_wait_r;
  logic [BYTE_W-1:0]   long_wait_r;
  logic                in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  i2cm_step u_step (
    .cur        (state_r),
    .kind       (in_kind),
    .data       (in_data),
    .sda_in     (in_sda_in),
    .short_wait (short_wait_r),
    .long_wait  (long_wait_r),
    .nxt        (state_nxt),
    .res        (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_wait_r <= SHORT_WAIT_RST;
      long_wait_r  <= LONG_WAIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHORT_WAIT: short_wait_r <= cfg_wdata;
        REG_LONG_WAIT:  long_wait_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase     <= PH_IDLE;
      state_r.cmd       <= KIND_TICK;
      state_r.bitc      <= '0;
      state_r.shift     <= '0;
      state_r.waitc     <= '0;
      state_r.scl       <= 1'b1;
      state_r.sda       <= 1'b1;
      state_r.ack       <= 1'b0;
      state_r.read_hold <= '0;
      out_valid_r       <= 1'b0;
    end else if (in_fire) begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, loaded with each input transaction
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_scl_level = res_r.scl_level;
  assign out_sda_level = res_r.sda_level;
  assign out_busy_res  = res_r.busy_res;
  assign out_done_res  = res_r.done_res;
  assign out_no_ack    = res_r.no_ack;
  assign out_read_byte = res_r.read_byte;
  assign out_rejected  = res_r.rejected;

`ifndef SYNTHESIS
  a_busy_tracks_phase: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (out_busy_res == (state_r.phase != PH_IDLE)))
    else $error("busy result disagrees with engine phase");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_done_res && out_busy_res))
    else $error("result is both done and busy");

  a_reject_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rejected) |-> (out_busy_res && !out_done_res))
    else $error("rejected command changed the sequence");

  a_idle_wait_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == PH_IDLE) |-> (state_r.waitc == '0))
    else $error("wait counter running while idle");
`endif

endmodule
